// ----- src/swarm_aggregation_motion_fsm_unit_assert.svh -----
// Assertion macros for the swarm aggregation motion controller.
`ifndef SWARM_AGGREGATION_MOTION_FSM_UNIT_ASSERT_SVH
`define SWARM_AGGREGATION_MOTION_FSM_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define SAMF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("samf: same-cycle check failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define SAMF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("samf: next-cycle check failed");

`endif

// ----- src/samf_pkg.sv -----
// Shared types and constants of the swarm aggregation motion controller.
package samf_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_DECIDE_PERIOD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_DISTANCE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_LEFT       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_RIGHT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STRAIGHT_LEFT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STRAIGHT_RIGHT  = 3'd5;

  localparam logic [7:0] DECIDE_PERIOD_RST = 8'd32;
  localparam logic [7:0] STOP_DISTANCE_RST = 8'd40;

  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_MESSAGE = 1'b1;

  typedef enum logic [1:0] {
    MOT_STOP     = 2'd0,
    MOT_STRAIGHT = 2'd1,
    MOT_LEFT     = 2'd2,
    MOT_RIGHT    = 2'd3
  } motion_t;

  typedef enum logic [1:0] {
    PH_SEARCH   = 2'd0,
    PH_CONVERGE = 2'd1,
    PH_SLEEP    = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] decide_period;
    logic [7:0] stop_distance;
    logic [7:0] turn_left_speed;
    logic [7:0] turn_right_speed;
    logic [7:0] straight_left_speed;
    logic [7:0] straight_right_speed;
  } cfg_t;

  // Elapsed ticks since the last decision never exceed 255 between items.
  typedef struct packed {
    phase_t     phase;
    motion_t    motion;
    logic [7:0] elapsed;
    logic       msg_seen;
    logic       latest_vld;
    logic [7:0] latest;
    logic       prev_vld;
    logic [7:0] prev;
    logic [7:0] drive_left;
    logic [7:0] drive_right;
  } state_t;

  typedef struct packed {
    motion_t    motion;
    logic [7:0] left_drive;
    logic [7:0] right_drive;
    logic       spinup;
    phase_t     phase;
  } res_t;

endpackage

// ----- src/swarm_aggregation_motion_fsm_unit.sv -----
// Top level of the swarm aggregation motion controller.
//
// Usage:
//   Input channel (in_valid / in_stall): one beat is either a clock tick
//   (in_action = 0) or a received message with its distance (in_action = 1),
//   together with two fresh random bits. Every beat yields exactly one
//   result beat on the output channel (out_valid / out_stall) with the
//   current motion, applied motor drives, spin-up pulse and phase.
//   Configuration channel (cfg_valid / cfg_ready): cfg_ready is always high;
//   write only while no beat is in flight. Unknown indexes are dropped.
// Path: an accepted input beat is held in the input register, decided
//   combinationally and loaded into the result register, which drives
//   out_valid.
// Throughput: one beat per cycle while out_stall is low, set by the
//   single registered decision pass between the input and result registers.
// Reset (rst_n low, synchronous): phase searching, motion stop, drives zero,
//   no distance held, tick count zero, registers at their defaults, both
//   pipeline stages empty.
// Receiver stall: the result register holds; the input register still
//   fills once, then in_stall rises until the result beat is taken.
module swarm_aggregation_motion_fsm_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_action,
  input  logic [7:0]                     in_distance,
  input  logic [1:0]                     in_random_bits,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_motion,
  output logic [7:0]                     out_left_drive,
  output logic [7:0]                     out_right_drive,
  output logic                           out_spinup,
  output logic [1:0]                     out_phase_out,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [samf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import samf_pkg::*;

  `include "swarm_aggregation_motion_fsm_unit_assert.svh"

  cfg_t       cfg;

  // Input stage
  logic       in_v_r;
  logic       in_action_r;
  logic [7:0] in_distance_r;
  logic [1:0] in_random_bits_r;
  logic       in_load;

  // Controller state
  state_t     st_r;
  state_t     st_nxt;

  // Result stage
  logic       out_v_r;
  res_t       out_res_r;
  res_t       res_nxt;
  logic       out_load;

  // Result register flags used by the checks below
  logic       res_stop;
  logic       res_sleep;
  logic       res_no_drive;

  assign cfg_ready = 1'b1;

  samf_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg_o   (cfg)
  );

  samf_decide u_decide (
    .cfg_i         (cfg),
    .st_i          (st_r),
    .action_i      (in_action_r),
    .distance_i    (in_distance_r),
    .random_bits_i (in_random_bits_r),
    .st_o          (st_nxt),
    .res_o         (res_nxt)
  );

  // Advance the held beat when the result register is empty or being drained.
  assign out_load = in_v_r && (!out_v_r || !out_stall);
  // Take a new beat when the input register is empty or moving on this cycle.
  assign in_stall = in_v_r && !out_load;
  assign in_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_action_r      <= in_action;
      in_distance_r    <= in_distance;
      in_random_bits_r <= in_random_bits;
    end
  end

  // Commit controller state only when the beat's result is loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase       <= PH_SEARCH;
      st_r.motion      <= MOT_STOP;
      st_r.elapsed     <= 8'd0;
      st_r.msg_seen    <= 1'b0;
      st_r.latest_vld  <= 1'b0;
      st_r.latest      <= 8'd0;
      st_r.prev_vld    <= 1'b0;
      st_r.prev        <= 8'd0;
      st_r.drive_left  <= 8'd0;
      st_r.drive_right <= 8'd0;
    end else if (out_load) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || !out_stall) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid       = out_v_r;
  assign out_motion      = 2'(out_res_r.motion);
  assign out_left_drive  = out_res_r.left_drive;
  assign out_right_drive = out_res_r.right_drive;
  assign out_spinup      = out_res_r.spinup;
  assign out_phase_out   = 2'(out_res_r.phase);

  assign res_stop     = (out_res_r.motion == MOT_STOP);
  assign res_sleep    = (out_res_r.phase == PH_SLEEP);
  assign res_no_drive = (out_res_r.left_drive == 8'd0) && (out_res_r.right_drive == 8'd0);

  // Spin-up only accompanies a moving motion.
  `SAMF_ASSERT_IMP(a_spin_moving, out_v_r && out_res_r.spinup, !res_stop)
  // Sleeping always keeps the robot stopped.
  `SAMF_ASSERT_IMP(a_sleep_stopped, out_v_r && res_sleep, res_stop)
  // A stopped robot applies no drive.
  `SAMF_ASSERT_IMP(a_stop_no_drive, out_v_r && res_stop, res_no_drive)
  // A decided beat shows up in the result register on the next cycle.
  `SAMF_ASSERT_NXT(a_load_shows, out_load, out_v_r)

endmodule

// ----- src/samf_cfg_regs.sv -----
// Configuration register file of the motion controller.
module samf_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [samf_pkg::CFG_IDX_W-1:0] wr_idx,
  input  logic [7:0]                    wr_data,
  output samf_pkg::cfg_t                cfg_o
);
  import samf_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_idx)
        CFG_DECIDE_PERIOD:  cfg_nxt.decide_period        = wr_data;
        CFG_STOP_DISTANCE:  cfg_nxt.stop_distance        = wr_data;
        CFG_TURN_LEFT:      cfg_nxt.turn_left_speed      = wr_data;
        CFG_TURN_RIGHT:     cfg_nxt.turn_right_speed     = wr_data;
        CFG_STRAIGHT_LEFT:  cfg_nxt.straight_left_speed  = wr_data;
        CFG_STRAIGHT_RIGHT: cfg_nxt.straight_right_speed = wr_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decide_period        <= DECIDE_PERIOD_RST;
      cfg_r.stop_distance        <= STOP_DISTANCE_RST;
      cfg_r.turn_left_speed      <= 8'd0;
      cfg_r.turn_right_speed     <= 8'd0;
      cfg_r.straight_left_speed  <= 8'd0;
      cfg_r.straight_right_speed <= 8'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// ----- src/samf_decide.sv -----
// Per-item decision logic: phase transitions, motion choice and drive update.
module samf_decide (
  input  samf_pkg::cfg_t   cfg_i,
  input  samf_pkg::state_t st_i,
  input  logic             action_i,
  input  logic [7:0]       distance_i,
  input  logic [1:0]       random_bits_i,
  output samf_pkg::state_t st_o,
  output samf_pkg::res_t   res_o
);
  import samf_pkg::*;

  logic [8:0] elapsed_inc;
  logic       decide;
  logic       at_stop;
  logic       grew;

  phase_t     phase_nxt;
  logic [7:0] elapsed_nxt;
  logic       msg_seen_nxt;
  logic       latest_vld_nxt;
  logic [7:0] latest_nxt;
  logic       prev_vld_nxt;
  logic [7:0] prev_nxt;
  logic       apply_en;
  motion_t    tgt_motion;

  motion_t    motion_nxt;
  logic [7:0] drive_left_nxt;
  logic [7:0] drive_right_nxt;
  logic       spin;

  assign elapsed_inc = {1'b0, st_i.elapsed} + 9'd1;
  assign decide      = (action_i == ACT_TICK) && (elapsed_inc > {1'b0, cfg_i.decide_period});
  // No distance counts as at or below the stop distance.
  assign at_stop     = !st_i.latest_vld || (st_i.latest <= cfg_i.stop_distance);
  assign grew        = st_i.latest_vld && (!st_i.prev_vld || (st_i.latest > st_i.prev));

  // Next phase and the motion that the phase asks for.
  always_comb begin
    phase_nxt      = st_i.phase;
    elapsed_nxt    = st_i.elapsed;
    msg_seen_nxt   = st_i.msg_seen;
    latest_vld_nxt = st_i.latest_vld;
    latest_nxt     = st_i.latest;
    prev_vld_nxt   = st_i.prev_vld;
    prev_nxt       = st_i.prev;
    apply_en       = 1'b0;
    tgt_motion     = st_i.motion;

    if (action_i == ACT_MESSAGE) begin
      msg_seen_nxt   = 1'b1;
      latest_vld_nxt = 1'b1;
      latest_nxt     = distance_i;
    end else if (!decide) begin
      elapsed_nxt = elapsed_inc[7:0];
    end else begin
      elapsed_nxt = 8'd0;
      case (st_i.phase)
        PH_SEARCH: begin
          apply_en = 1'b1;
          if (st_i.msg_seen) begin
            msg_seen_nxt = 1'b0;
            phase_nxt    = PH_CONVERGE;
            tgt_motion   = MOT_STRAIGHT;
            prev_vld_nxt = st_i.latest_vld;
            prev_nxt     = st_i.latest;
          end else if (random_bits_i == 2'd1) begin
            tgt_motion = MOT_LEFT;
          end else if (random_bits_i == 2'd2) begin
            tgt_motion = MOT_RIGHT;
          end else begin
            tgt_motion = MOT_STRAIGHT;
          end
        end
        PH_CONVERGE: begin
          if (at_stop) begin
            phase_nxt  = PH_SLEEP;
            apply_en   = 1'b1;
            tgt_motion = MOT_STOP;
          end else begin
            if (grew) begin
              apply_en = 1'b1;
              if (st_i.motion == MOT_RIGHT) begin
                tgt_motion = MOT_LEFT;
              end else if (st_i.motion == MOT_LEFT) begin
                tgt_motion = MOT_RIGHT;
              end else begin
                tgt_motion = random_bits_i[0] ? MOT_RIGHT : MOT_LEFT;
              end
            end
            prev_vld_nxt = st_i.latest_vld;
            prev_nxt     = st_i.latest;
          end
        end
        default: begin
          apply_en   = 1'b1;
          tgt_motion = MOT_STOP;
        end
      endcase
    end
  end

  // Reload drives only on a real motion change; raise spin-up for moving motions.
  always_comb begin
    motion_nxt      = st_i.motion;
    drive_left_nxt  = st_i.drive_left;
    drive_right_nxt = st_i.drive_right;
    spin            = 1'b0;
    if (apply_en && (tgt_motion != st_i.motion)) begin
      motion_nxt = tgt_motion;
      case (tgt_motion)
        MOT_LEFT: begin
          spin            = 1'b1;
          drive_left_nxt  = cfg_i.turn_left_speed;
          drive_right_nxt = 8'd0;
        end
        MOT_RIGHT: begin
          spin            = 1'b1;
          drive_left_nxt  = 8'd0;
          drive_right_nxt = cfg_i.turn_right_speed;
        end
        MOT_STRAIGHT: begin
          spin            = 1'b1;
          drive_left_nxt  = cfg_i.straight_left_speed;
          drive_right_nxt = cfg_i.straight_right_speed;
        end
        default: begin
          drive_left_nxt  = 8'd0;
          drive_right_nxt = 8'd0;
        end
      endcase
    end
  end

  always_comb begin
    st_o.phase       = phase_nxt;
    st_o.motion      = motion_nxt;
    st_o.elapsed     = elapsed_nxt;
    st_o.msg_seen    = msg_seen_nxt;
    st_o.latest_vld  = latest_vld_nxt;
    st_o.latest      = latest_nxt;
    st_o.prev_vld    = prev_vld_nxt;
    st_o.prev        = prev_nxt;
    st_o.drive_left  = drive_left_nxt;
    st_o.drive_right = drive_right_nxt;

    res_o.motion      = motion_nxt;
    res_o.left_drive  = drive_left_nxt;
    res_o.right_drive = drive_right_nxt;
    res_o.spinup      = spin;
    res_o.phase       = phase_nxt;
  end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the swarm aggregation motion controller.
`timescale 1ns / 100ps

module tb;
  import samf_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DIR_ROWS     = 24;
  localparam int RANDOM_BEATS = 400;
  localparam int FINAL_BEATS  = 50;
  localparam int DRAIN_CYCLES = 4;

  // Index past the last mapped register; the block must drop writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
  localparam res_t NO_CHECK = '0;

  // One directed row: the input beat, plus a hand-typed result where the
  // answer is obvious; otherwise the controller model decides.
  typedef struct {
    logic       action;
    logic [7:0] dist_val;
    logic [1:0] rnd;
    logic       fixed;
    res_t       want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_action = 1'b0;
  logic [7:0]           in_distance = 8'd0;
  logic [1:0]           in_random_bits = 2'd0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_motion;
  logic [7:0]           out_left_drive;
  logic [7:0]           out_right_drive;
  logic                 out_spinup;
  logic [1:0]           out_phase_out;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = 8'd0;

  // Controller model state, kept in step with every accepted beat.
  cfg_t              shadow_cfg;
  phase_t            cur_phase;
  motion_t           cur_motion;
  logic [31:0]       tick_count;
  logic [31:0]       last_decision;
  logic              msg_seen;
  logic signed [8:0] latest_d;
  logic signed [8:0] prev_d;
  logic [7:0]        drv_l;
  logic [7:0]        drv_r;
  logic              spin;

  res_t      expected_results[$];
  stim_row_t dir_rows[DIR_ROWS];
  int        fails = 0;
  int        cycles = 0;
  int        tx_idle_pct = 0;
  int        rx_stall_pct = 0;
  int        stop_sel;

  swarm_aggregation_motion_fsm_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_distance     (in_distance),
    .in_random_bits  (in_random_bits),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_motion      (out_motion),
    .out_left_drive  (out_left_drive),
    .out_right_drive (out_right_drive),
    .out_spinup      (out_spinup),
    .out_phase_out   (out_phase_out),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Switch motors to a new motion; reload drives only on an actual change,
  // so register writes made since the last change stay invisible.
  function automatic void load_motion(motion_t m);
    if (m == cur_motion) return;
    case (m)
      MOT_LEFT: begin
        spin  = 1'b1;
        drv_l = shadow_cfg.turn_left_speed;
        drv_r = 8'd0;
      end
      MOT_RIGHT: begin
        spin  = 1'b1;
        drv_l = 8'd0;
        drv_r = shadow_cfg.turn_right_speed;
      end
      MOT_STRAIGHT: begin
        spin  = 1'b1;
        drv_l = shadow_cfg.straight_left_speed;
        drv_r = shadow_cfg.straight_right_speed;
      end
      default: begin
        drv_l = 8'd0;
        drv_r = 8'd0;
      end
    endcase
    cur_motion = m;
  endfunction

  // Advance the controller by one beat and return the result it reports.
  function automatic res_t step_controller(logic action, logic [7:0] dist_val, logic [1:0] rnd);
    res_t r;
    spin = 1'b0;
    if (action == ACT_MESSAGE) begin
      // A message only latches the distance; it never triggers a decision.
      msg_seen = 1'b1;
      latest_d = signed'({1'b0, dist_val});
    end else begin
      tick_count = tick_count + 32'd1;
      // Elapsed count is modulo 2^32, so counter wrap needs no care.
      if (tick_count - last_decision > {24'd0, shadow_cfg.decide_period}) begin
        last_decision = tick_count;
        case (cur_phase)
          PH_SEARCH: begin
            if (msg_seen) begin
              msg_seen  = 1'b0;
              cur_phase = PH_CONVERGE;
              load_motion(MOT_STRAIGHT);
              prev_d = latest_d;
            end else begin
              case (rnd)
                2'd1:    load_motion(MOT_LEFT);
                2'd2:    load_motion(MOT_RIGHT);
                default: load_motion(MOT_STRAIGHT);
              endcase
            end
          end
          PH_CONVERGE: begin
            // No distance held reads as -1, i.e. below every stop distance.
            if (latest_d <= signed'({1'b0, shadow_cfg.stop_distance})) begin
              cur_phase = PH_SLEEP;
              load_motion(MOT_STOP);
            end else begin
              if (latest_d > prev_d) begin
                // Distance grew: flip the turn, or start one when not turning.
                if (cur_motion == MOT_RIGHT) load_motion(MOT_LEFT);
                else if (cur_motion == MOT_LEFT) load_motion(MOT_RIGHT);
                else load_motion(rnd[0] ? MOT_RIGHT : MOT_LEFT);
              end
              prev_d = latest_d;
            end
          end
          default: load_motion(MOT_STOP);
        endcase
      end
    end
    r.motion      = cur_motion;
    r.left_drive  = drv_l;
    r.right_drive = drv_r;
    r.spinup      = spin;
    r.phase       = cur_phase;
    return r;
  endfunction

  // Write one register; leave cfg_valid high so back-to-back writes need a
  // single assignment per step. The caller drops it after the batch.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    logic took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    case (idx)
      CFG_DECIDE_PERIOD:  shadow_cfg.decide_period        = val;
      CFG_STOP_DISTANCE:  shadow_cfg.stop_distance        = val;
      CFG_TURN_LEFT:      shadow_cfg.turn_left_speed      = val;
      CFG_TURN_RIGHT:     shadow_cfg.turn_right_speed     = val;
      CFG_STRAIGHT_LEFT:  shadow_cfg.straight_left_speed  = val;
      CFG_STRAIGHT_RIGHT: shadow_cfg.straight_right_speed = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [7:0] period, input logic [7:0] stop_dist,
                              input logic [7:0] tl, input logic [7:0] tr,
                              input logic [7:0] sl, input logic [7:0] sr);
    cfg_write(CFG_DECIDE_PERIOD, period);
    cfg_write(CFG_STOP_DISTANCE, stop_dist);
    cfg_write(CFG_TURN_LEFT, tl);
    cfg_write(CFG_TURN_RIGHT, tr);
    cfg_write(CFG_STRAIGHT_LEFT, sl);
    cfg_write(CFG_STRAIGHT_RIGHT, sr);
    cfg_valid <= 1'b0;
  endtask

  // Offer one beat after a random idle gap and hold it until taken. The
  // stall seen at the falling edge is the one the next rising edge uses.
  task automatic send_beat(input logic action, input logic [7:0] dist_val,
                           input logic [1:0] rnd, input logic fixed, input res_t want);
    logic took;
    res_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= action;
    in_distance    <= dist_val;
    in_random_bits <= rnd;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    predicted = step_controller(action, dist_val, rnd);
    expected_results.push_back(fixed ? want : predicted);
  endtask

  // Mostly ticks; messages carry distances kept above the stop threshold
  // most of the time so converging lasts, with the full range now and then.
  task automatic random_beats(input int count, input int dist_floor);
    logic       action;
    logic [7:0] dist_val;
    for (int i = 0; i < count; i++) begin
      action = ($urandom_range(0, 7) == 0) ? ACT_MESSAGE : ACT_TICK;
      if (dist_floor > 255 || $urandom_range(0, 11) == 0) dist_val = 8'($urandom_range(0, 255));
      else dist_val = 8'($urandom_range(dist_floor, 255));
      send_beat(action, dist_val, 2'($urandom_range(0, 3)), 1'b0, NO_CHECK);
    end
  endtask

  // Park the sender and hold until every pending result has come back.
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < rx_stall_pct);

  // A beat seen valid and unstalled at the falling edge is taken at the next
  // rising edge; check it against the oldest pending result.
  always @(negedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no pending expectation");
        fails++;
      end else begin
        want = expected_results.pop_front();
        if (out_motion !== want.motion) begin
          $error("motion: expected %0d, got %0d", want.motion, out_motion);
          fails++;
        end
        if (out_left_drive !== want.left_drive) begin
          $error("left_drive: expected %0d, got %0d", want.left_drive, out_left_drive);
          fails++;
        end
        if (out_right_drive !== want.right_drive) begin
          $error("right_drive: expected %0d, got %0d", want.right_drive, out_right_drive);
          fails++;
        end
        if (out_spinup !== want.spinup) begin
          $error("spinup: expected %0d, got %0d", want.spinup, out_spinup);
          fails++;
        end
        if (out_phase_out !== want.phase) begin
          $error("phase_out: expected %0d, got %0d", want.phase, out_phase_out);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    // Model state out of reset.
    shadow_cfg    = '0;
    shadow_cfg.decide_period = DECIDE_PERIOD_RST;
    shadow_cfg.stop_distance = STOP_DISTANCE_RST;
    cur_phase     = PH_SEARCH;
    cur_motion    = MOT_STOP;
    tick_count    = 32'd0;
    last_decision = 32'd0;
    msg_seen      = 1'b0;
    latest_d      = -9'sd1;
    prev_d        = -9'sd1;
    drv_l         = 8'd0;
    drv_r         = 8'd0;
    spin          = 1'b0;

    // Directed walk with a decision every second tick: every random heading
    // in search, entry to converging, a shrunk distance, a grown distance
    // from straight and from a turn, and a distance one above the threshold.
    dir_rows = '{
      '{ACT_TICK,    8'd0,   2'd0, 1'b1, '{MOT_STOP, 8'h00, 8'h00, 1'b0, PH_SEARCH}},
      '{ACT_TICK,    8'd255, 2'd1, 1'b1, '{MOT_LEFT, 8'hFF, 8'h00, 1'b1, PH_SEARCH}},
      '{ACT_TICK,    8'd0,   2'd2, 1'b0, NO_CHECK},
      '{ACT_TICK,    8'd0,   2'd2, 1'b0, NO_CHECK},
      '{ACT_TICK,    8'd0,   2'd3, 1'b0, NO_CHECK},
      '{ACT_TICK,    8'd0,   2'd3, 1'b0, NO_CHECK},
      '{ACT_TICK,    8'd0,   2'd0, 1'b0, NO_CHECK},
      '{ACT_TICK,    8'd0,   2'd0, 1'b0, NO_CHECK},
      '{ACT_MESSAGE, 8'd0,   2'd3, 1'b1, '{MOT_STRAIGHT, 8'hAA, 8'h55, 1'b0, PH_SEARCH}},
      '{ACT_MESSAGE, 8'd255, 2'd0, 1'b0, NO_CHECK},
      '{ACT_TICK,    8'd0,   2'd0, 1'b0, NO_CHECK},
      '{ACT_TICK,    8'd0,   2'd0, 1'b0, NO_CHECK},
      '{ACT_MESSAGE, 8'd200, 2'd0, 1'b0, NO_CHECK},
      '{ACT_TICK,    8'd0,   2'd0, 1'b0, NO_CHECK},
      '{ACT_TICK,    8'd0,   2'd0, 1'b0, NO_CHECK},
      '{ACT_MESSAGE, 8'd230, 2'd0, 1'b0, NO_CHECK},
      '{ACT_TICK,    8'd0,   2'd1, 1'b0, NO_CHECK},
      '{ACT_TICK,    8'd0,   2'd1, 1'b0, NO_CHECK},
      '{ACT_MESSAGE, 8'd250, 2'd0, 1'b0, NO_CHECK},
      '{ACT_TICK,    8'd0,   2'd0, 1'b0, NO_CHECK},
      '{ACT_TICK,    8'd0,   2'd0, 1'b0, NO_CHECK},
      '{ACT_MESSAGE, 8'd101, 2'd0, 1'b0, NO_CHECK},
      '{ACT_TICK,    8'd0,   2'd0, 1'b0, NO_CHECK},
      '{ACT_TICK,    8'd0,   2'd0, 1'b0, NO_CHECK}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Sender sparse-ish, receiver mostly stalled.
    tx_idle_pct  = 31;
    rx_stall_pct = 85;
    cfg_write(CFG_UNMAPPED, 8'h03);
    program_regs(8'd1, 8'd100, 8'hFF, 8'h01, 8'hAA, 8'h55);
    foreach (dir_rows[i])
      send_beat(dir_rows[i].action, dir_rows[i].dist_val, dir_rows[i].rnd,
                dir_rows[i].fixed, dir_rows[i].want);

    // Short decide period, stop threshold at zero: converging runs long.
    drain;
    program_regs(8'($urandom_range(1, 6)), 8'd0, 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
    random_beats(RANDOM_BEATS, 1);

    // Swap pressure; longest decide period and extreme drive values.
    drain;
    tx_idle_pct  = 85;
    rx_stall_pct = 31;
    stop_sel = $urandom_range(1, 60);
    program_regs(8'd255, 8'(stop_sel), 8'd0, 8'd255, 8'd255, 8'd0);
    random_beats(RANDOM_BEATS, stop_sel + 1);

    // Full rate on both sides.
    drain;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    stop_sel = $urandom_range(20, 120);
    program_regs(8'($urandom_range(1, 3)), 8'(stop_sel), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
    random_beats(RANDOM_BEATS, stop_sel + 1);

    // Highest stop threshold: the next converging decision goes to sleep.
    drain;
    program_regs(8'd1, 8'd255, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    random_beats(FINAL_BEATS, 256);

    drain;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/samf_pkg.sv
src/samf_cfg_regs.sv
src/samf_decide.sv
src/swarm_aggregation_motion_fsm_unit.sv
tb/tb.sv
